// ----- hdl/lcov_pkg.sv -----
package lcov_pkg;

    localparam int CHANNELS     = 4;
    localparam int MAX_LAGS     = 8;
    localparam int MAX_CUTS     = 4;
    localparam int MAX_ANTENNAS = 16;
    localparam int MAX_POINTS   = 4096;
    localparam int SAMP_W       = 16;
    localparam int PROD_W       = 2 * SAMP_W;
    localparam int ACC_W        = 45;
    localparam int OUT_W        = 46;
    localparam int ANT_W        = 4;
    localparam int ADDR_W       = 2 * ANT_W;
    localparam int BANK_DEPTH   = 1 << ADDR_W;
    localparam int CH_W         = $clog2(CHANNELS);
    localparam int LAG_W        = $clog2(MAX_LAGS);
    localparam int PAIRS        = CHANNELS * CHANNELS;
    localparam int PAIR_W       = 2 * CH_W;
    localparam int CUT_W        = $clog2(MAX_CUTS);
    localparam int SIC_W        = $clog2(MAX_POINTS) + 1;
    localparam int MAP_W        = 64;

    typedef logic signed [SAMP_W-1:0] t_samp;

    typedef struct packed {
        t_samp re;
        t_samp im;
    } t_cplx;

    typedef t_cplx [CHANNELS-1:0] t_slot;

    // One channel pair handed to every lag cell in the same cycle.
    typedef struct packed {
        logic              valid;
        logic              clear;
        logic [ADDR_W-1:0] addr;
        logic [CH_W-1:0]   ch;
        t_cplx             xj;
    } t_cell_cmd;

    typedef struct packed {
        logic                    tag;
        logic signed [ACC_W-1:0] re;
        logic signed [ACC_W-1:0] im;
    } t_acc_rd;

    function automatic logic [ANT_W-1:0] f_antenna(input logic [MAP_W-1:0] map,
                                                   input logic [CUT_W-1:0] cut,
                                                   input logic [CH_W-1:0]  ch);
        logic [5:0] pos;
        pos = {cut, ch, 2'b00};
        return map[pos +: ANT_W];
    endfunction

    // A pair loses when a later pair in row-major order lands on the same antenna pair.
    function automatic logic [PAIRS-1:0] f_pair_win(input logic [MAP_W-1:0] map,
                                                    input logic [CUT_W-1:0] cut,
                                                    input logic [2:0]       nch);
        logic [PAIRS-1:0] win;
        logic [ANT_W-1:0] ant [CHANNELS];
        for (int c = 0; c < CHANNELS; c++) begin
            ant[c] = f_antenna(map, cut, CH_W'(c));
        end
        for (int n = 0; n < PAIRS; n++) begin
            win[n] = 1'b1;
            for (int m = n + 1; m < PAIRS; m++) begin
                if ((m / CHANNELS) < int'(nch) && (m % CHANNELS) < int'(nch) &&
                    ant[m / CHANNELS] == ant[n / CHANNELS] &&
                    ant[m % CHANNELS] == ant[n % CHANNELS]) begin
                    win[n] = 1'b0;
                end
            end
        end
        return win;
    endfunction

endpackage

// ----- hdl/lagged_covariance_accumulator.sv -----
// Lagged covariance accumulator. A row of lag cells, one per lag, each holds one
// past snapshot and its own bank of the covariance store; a snapshot shifts down the
// row and then the sixteen channel pairs are stepped through all cells in parallel,
// one pair a cycle; after the pairs the read-modify-write pipeline of the banks
// drains before the next item is taken. A read steps through the states ST_RD1
// and ST_RD2 and waits in ST_RD2 for the output register to be free. After reset
// and after every start item the covariance store and its coverage tags are cleared
// entry by entry, during which no item is taken; configuration writes are accepted at any time.
module lagged_covariance_accumulator import lcov_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // ch0_re, ch0_im, ch1_re, ch1_im, ch2_re, ch2_im, ch3_re, ch3_im, entry_index, zero pad
    input  logic [143:0] i_s_tdata,
    // mode
    input  logic [1:0]   i_s_tuser,
    input  logic         i_s_tlast,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // entry_re, entry_im, zero pad
    output logic [95:0]  o_m_tdata,
    // entry_covered
    output logic [0:0]   o_m_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [63:0]  i_cfg_data
);

    localparam logic [1:0] MODE_SNAP  = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_START = 2'd2;

    localparam logic [2:0] CFG_CHANNELS = 3'd0;
    localparam logic [2:0] CFG_CUTS     = 3'd1;
    localparam logic [2:0] CFG_LAGS     = 3'd2;
    localparam logic [2:0] CFG_ANTENNAS = 3'd3;
    localparam logic [2:0] CFG_CUT_MAP  = 3'd4;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_RUN   = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_RD1   = 3'd4;
    localparam logic [2:0] ST_RD2   = 3'd5;

    logic [2:0]       r_ch_used, r_cut_cnt;
    logic [3:0]       r_lag_cnt;
    logic [4:0]       r_ant_cnt;
    logic [MAP_W-1:0] r_cut_map;

    logic [2:0]        r_state;
    logic [ADDR_W-1:0] r_clr_addr;
    logic [PAIR_W-1:0] r_pair;
    logic              r_drain;
    logic [SIC_W-1:0]  r_sic;
    logic [CUT_W-1:0]  r_cut;
    logic              r_last;
    logic [10:0]       r_idx;

    logic                    r_ov;
    logic signed [OUT_W-1:0] r_out_re, r_out_im;
    logic                    r_out_cov;

    logic [2:0] nch, ncut;
    logic [3:0] nlag;
    logic [4:0] nant;

    logic             accept, snap_take, out_free;
    logic [CUT_W:0]   cut_inc;
    logic [CUT_W-1:0] n_cut_adv;
    logic [PAIRS-1:0] win;
    logic [CH_W-1:0]  pi, pj;
    logic [ANT_W-1:0] ant_a, ant_b;
    logic             pair_ok;
    t_cell_cmd        cmd;
    t_slot            new_slot;
    t_slot            slot_out [MAX_LAGS];
    t_acc_rd          rd_a [MAX_LAGS];
    t_acc_rd          rd_b [MAX_LAGS];
    logic [MAX_LAGS-1:0] lag_en, lag_use;

    t_acc_rd                 sel_a, sel_b;
    logic                    in_range;
    logic signed [OUT_W-1:0] n_out_re, n_out_im;

    always_comb begin
        nch  = (r_ch_used == '0) ? 3'd1 : ((r_ch_used > 3'(CHANNELS)) ? 3'(CHANNELS) : r_ch_used);
        ncut = (r_cut_cnt == '0) ? 3'd1 : ((r_cut_cnt > 3'(MAX_CUTS)) ? 3'(MAX_CUTS) : r_cut_cnt);
        nlag = (r_lag_cnt == '0) ? 4'd1 : ((r_lag_cnt > 4'(MAX_LAGS)) ? 4'(MAX_LAGS) : r_lag_cnt);
        nant = (r_ant_cnt == '0) ? 5'd1 :
               ((r_ant_cnt > 5'(MAX_ANTENNAS)) ? 5'(MAX_ANTENNAS) : r_ant_cnt);
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch_used <= 3'd4;
            r_cut_cnt <= 3'd1;
            r_lag_cnt <= 4'd8;
            r_ant_cnt <= 5'd16;
            r_cut_map <= 64'h3210;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CHANNELS: r_ch_used <= i_cfg_data[2:0];
                CFG_CUTS:     r_cut_cnt <= i_cfg_data[2:0];
                CFG_LAGS:     r_lag_cnt <= i_cfg_data[3:0];
                CFG_ANTENNAS: r_ant_cnt <= i_cfg_data[4:0];
                CFG_CUT_MAP:  r_cut_map <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;
    assign snap_take  = r_sic < SIC_W'(MAX_POINTS);
    assign out_free   = !r_ov || i_m_tready;
    assign cut_inc    = {1'b0, r_cut} + 1'b1;
    assign n_cut_adv  = (3'(cut_inc) >= ncut) ? '0 : cut_inc[CUT_W-1:0];

    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            new_slot[c].re = i_s_tdata[32*c +: SAMP_W];
            new_slot[c].im = i_s_tdata[32*c+16 +: SAMP_W];
        end
    end

    assign win     = f_pair_win(r_cut_map, r_cut, nch);
    assign pi      = r_pair[PAIR_W-1:CH_W];
    assign pj      = r_pair[CH_W-1:0];
    assign ant_a   = f_antenna(r_cut_map, r_cut, pi);
    assign ant_b   = f_antenna(r_cut_map, r_cut, pj);
    assign pair_ok = (3'(pi) < nch) && (3'(pj) < nch) && (5'(ant_a) < nant) &&
                     (5'(ant_b) < nant) && win[r_pair];

    always_comb begin
        cmd.valid = (r_state == ST_RUN) && pair_ok;
        cmd.clear = (r_sic == '0);
        cmd.addr  = {ant_a, ant_b};
        cmd.ch    = pi;
        cmd.xj    = slot_out[0][pj];
    end

    genvar k;
    generate
        for (k = 0; k < MAX_LAGS; k++) begin : g_cell
            assign lag_en[k]  = 4'(k) < nlag;
            assign lag_use[k] = SIC_W'(k) <= r_sic;

            lcov_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_shift     (accept && i_s_tuser == MODE_SNAP && snap_take),
                .i_wipe      (accept && i_s_tuser == MODE_START),
                .i_slot      ((k == 0) ? new_slot : slot_out[(k == 0) ? 0 : k - 1]),
                .o_slot      (slot_out[k]),
                .i_cmd       (cmd),
                .i_lag_en    (lag_en[k]),
                .i_lag_use   (lag_use[k]),
                .i_rd_addr_a (r_idx[7:0]),
                .i_rd_addr_b ({r_idx[3:0], r_idx[7:4]}),
                .i_clr_en    (r_state == ST_CLEAR),
                .i_clr_addr  (r_clr_addr),
                .o_rd_a      (rd_a[k]),
                .o_rd_b      (rd_b[k])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_pair     <= '0;
            r_drain    <= 1'b0;
            r_sic      <= '0;
            r_cut      <= '0;
            r_last     <= 1'b0;
        end else begin
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (&r_clr_addr) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_s_tvalid) begin
                        unique case (i_s_tuser)
                            MODE_SNAP: begin
                                if (snap_take) begin
                                    r_state <= ST_RUN;
                                    r_pair  <= '0;
                                    r_last  <= i_s_tlast;
                                end else if (i_s_tlast) begin
                                    r_sic <= '0;
                                    r_cut <= n_cut_adv;
                                end
                            end
                            MODE_READ: r_state <= ST_RD1;
                            MODE_START: begin
                                r_sic      <= '0;
                                r_cut      <= '0;
                                r_clr_addr <= '0;
                                r_state    <= ST_CLEAR;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_RUN: begin
                    r_pair <= r_pair + 1'b1;
                    if (&r_pair) begin
                        r_state <= ST_DRAIN;
                        r_drain <= 1'b0;
                    end
                end
                ST_DRAIN: begin
                    if (r_drain) begin
                        r_state <= ST_IDLE;
                        if (r_last) begin
                            r_sic <= '0;
                            r_cut <= n_cut_adv;
                        end else begin
                            r_sic <= r_sic + 1'b1;
                        end
                    end else begin
                        r_drain <= 1'b1;
                    end
                end
                ST_RD1: r_state <= ST_RD2;
                ST_RD2: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_idx <= i_s_tdata[128 +: 11];
        end
    end

    assign sel_a    = rd_a[r_idx[8 +: LAG_W]];
    assign sel_b    = rd_b[r_idx[8 +: LAG_W]];
    assign in_range = ({1'b0, r_idx[10:8]} < nlag) && ({1'b0, r_idx[7:4]} < nant) &&
                      ({1'b0, r_idx[3:0]} < nant);
    assign n_out_re = in_range ? OUT_W'(sel_a.re) + OUT_W'(sel_b.re) : '0;
    assign n_out_im = in_range ? OUT_W'(sel_a.im) - OUT_W'(sel_b.im) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_state == ST_RD2 && out_free) begin
            r_ov <= 1'b1;
        end else if (i_m_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_RD2 && out_free) begin
            r_out_re  <= n_out_re;
            r_out_im  <= n_out_im;
            r_out_cov <= in_range && sel_a.tag && sel_b.tag;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {4'b0000, r_out_im, r_out_re};
    assign o_m_tuser  = r_out_cov;

endmodule

// ----- hdl/lcov_cell.sv -----
module lcov_cell import lcov_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_shift,
    input  logic              i_wipe,
    input  t_slot             i_slot,
    output t_slot             o_slot,
    input  t_cell_cmd         i_cmd,
    input  logic              i_lag_en,
    input  logic              i_lag_use,
    input  logic [ADDR_W-1:0] i_rd_addr_a,
    input  logic [ADDR_W-1:0] i_rd_addr_b,
    input  logic              i_clr_en,
    input  logic [ADDR_W-1:0] i_clr_addr,
    output t_acc_rd           o_rd_a,
    output t_acc_rd           o_rd_b
);

    t_slot r_slot;

    logic signed [ACC_W-1:0] r_mem_re  [BANK_DEPTH];
    logic signed [ACC_W-1:0] r_mem_im  [BANK_DEPTH];
    logic                    r_mem_tag [BANK_DEPTH];

    logic [ADDR_W-1:0]       addr_a;
    logic signed [ACC_W-1:0] r_rda_re, r_rda_im, r_rdb_re, r_rdb_im;
    logic                    r_rda_tag, r_rdb_tag;

    logic                     r_b_valid;
    logic [ADDR_W-1:0]        r_b_addr;
    logic                     r_b_clear;
    logic signed [PROD_W-1:0] r_pac, r_pbd, r_pbc, r_pad;

    logic                     r_c_valid;
    logic [ADDR_W-1:0]        r_c_addr;
    logic                     r_c_clear;
    logic                     r_c_use;
    logic signed [PROD_W:0]   r_c_psum_re, r_c_psum_im;
    logic signed [ACC_W-1:0]  r_c_base_re, r_c_base_im;
    logic signed [ACC_W-1:0]  n_acc_re, n_acc_im;

    t_cplx own;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_wipe) begin
            r_slot <= '0;
        end else if (i_shift) begin
            r_slot <= i_slot;
        end
    end

    assign o_slot = r_slot;
    assign addr_a = i_cmd.valid ? i_cmd.addr : i_rd_addr_a;
    assign own    = r_slot[i_cmd.ch];

    always_ff @(posedge i_clk) begin
        r_rda_re  <= r_mem_re[addr_a];
        r_rda_im  <= r_mem_im[addr_a];
        r_rda_tag <= r_mem_tag[addr_a];
        r_rdb_re  <= r_mem_re[i_rd_addr_b];
        r_rdb_im  <= r_mem_im[i_rd_addr_b];
        r_rdb_tag <= r_mem_tag[i_rd_addr_b];
    end

    // The clearing pass zeroes every entry, so an entry no cut has touched reads as zero.
    assign o_rd_a = '{tag: r_rda_tag, re: r_rda_re, im: r_rda_im};
    assign o_rd_b = '{tag: r_rdb_tag, re: r_rdb_re, im: r_rdb_im};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            r_b_valid <= i_cmd.valid & i_lag_en;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_addr    <= i_cmd.addr;
        r_b_clear   <= i_cmd.clear;
        r_pac       <= own.re * i_cmd.xj.re;
        r_pbd       <= own.im * i_cmd.xj.im;
        r_pbc       <= own.im * i_cmd.xj.re;
        r_pad       <= own.re * i_cmd.xj.im;
        r_c_addr    <= r_b_addr;
        r_c_clear   <= r_b_clear;
        r_c_use     <= i_lag_use;
        r_c_psum_re <= (PROD_W+1)'(r_pac) + (PROD_W+1)'(r_pbd);
        r_c_psum_im <= (PROD_W+1)'(r_pbc) - (PROD_W+1)'(r_pad);
        r_c_base_re <= o_rd_a.re;
        r_c_base_im <= o_rd_a.im;
    end

    assign n_acc_re = (r_c_clear ? '0 : r_c_base_re) + (r_c_use ? ACC_W'(r_c_psum_re) : '0);
    assign n_acc_im = (r_c_clear ? '0 : r_c_base_im) + (r_c_use ? ACC_W'(r_c_psum_im) : '0);

    always_ff @(posedge i_clk) begin
        if (i_clr_en) begin
            r_mem_re[i_clr_addr] <= '0;
            r_mem_im[i_clr_addr] <= '0;
        end else if (r_c_valid) begin
            r_mem_re[r_c_addr] <= n_acc_re;
            r_mem_im[r_c_addr] <= n_acc_im;
        end
    end

    // Only the first snapshot of a cut marks an entry as covered.
    always_ff @(posedge i_clk) begin
        if (i_clr_en) begin
            r_mem_tag[i_clr_addr] <= 1'b0;
        end else if (r_c_valid && r_c_clear) begin
            r_mem_tag[r_c_addr] <= 1'b1;
        end
    end

endmodule

// ----- tb/lagged_covariance_accumulator_tb.sv -----
module lagged_covariance_accumulator_tb;
    import lcov_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] MODE_SNAP  = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_START = 2'd2;
    localparam logic [1:0] MODE_NONE  = 2'd3;

    localparam logic [2:0] REG_CHANNELS = 3'd0;
    localparam logic [2:0] REG_CUTS     = 3'd1;
    localparam logic [2:0] REG_LAGS     = 3'd2;
    localparam logic [2:0] REG_ANTENNAS = 3'd3;
    localparam logic [2:0] REG_CUT_MAP  = 3'd4;

    localparam int STORE = MAX_LAGS * 256;
    // Long enough for a snapshot and a full clearing pass to finish.
    localparam int SETTLE_CYCLES = 300;

    typedef struct {
        logic [OUT_W-1:0] re;
        logic [OUT_W-1:0] im;
        bit               covered;
    } t_entry;

    typedef struct {
        logic [1:0]  mode;
        bit          last;
        logic [10:0] idx;
        logic [15:0] fill;
        bit          typed;
        t_entry      want;
    } t_stim_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [143:0] i_s_tdata = '0;
    logic [1:0]   i_s_tuser = '0;
    logic         i_s_tlast = 1'b0;
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [95:0]  o_m_tdata;
    logic [0:0]   o_m_tuser;
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [2:0]   i_cfg_index = '0;
    logic [63:0]  i_cfg_data = '0;

    lagged_covariance_accumulator u_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #15ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Mirror of the block's registers and stores.
    logic [2:0]  cov_channels;
    logic [2:0]  cov_cuts;
    logic [3:0]  cov_lags;
    logic [4:0]  cov_antennas;
    logic [63:0] cov_map;
    logic [31:0] past_snap [MAX_LAGS*CHANNELS];
    longint      acc_re [STORE];
    longint      acc_im [STORE];
    int          cut_tag [STORE];
    int          points_in_cut;
    int          cut_now;

    t_entry entries_due [$];
    int     errors = 0;
    int     entries_seen = 0;
    int     items_sent = 0;
    bit     no_idle = 1'b0;

    function automatic int clampi(int v, int lo, int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic int antenna(int cut, int ch);
        return int'((cov_map >> (4 * (4 * (cut & 3) + (ch & 3)))) & 64'hF);
    endfunction

    function automatic void clear_stores();
        foreach (past_snap[n]) past_snap[n] = '0;
        foreach (acc_re[n]) begin
            acc_re[n] = 0;
            acc_im[n] = 0;
            cut_tag[n] = 0;
        end
        points_in_cut = 0;
        cut_now = 0;
    endfunction

    // Only the last channel pair in row-major order that lands on an antenna pair counts.
    function automatic bit pair_counts(int i, int j, int nch);
        int a;
        int b;
        a = antenna(cut_now, i);
        b = antenna(cut_now, j);
        for (int p = 0; p < nch; p++)
            for (int q = 0; q < nch; q++)
                if (p * nch + q > i * nch + j && antenna(cut_now, p) == a &&
                    antenna(cut_now, q) == b)
                    return 1'b0;
        return 1'b1;
    endfunction

    function automatic void accumulate_snapshot(input logic [15:0] s [8], input bit last);
        int nch;
        int nlag;
        int nant;
        int a;
        int b;
        int addr;
        longint c;
        longint d;
        longint pa;
        longint pb;
        nch = clampi(cov_channels, 1, CHANNELS);
        nlag = clampi(cov_lags, 1, MAX_LAGS);
        nant = clampi(cov_antennas, 1, MAX_ANTENNAS);
        if (points_in_cut < MAX_POINTS) begin
            for (int n = MAX_LAGS * CHANNELS - 1; n >= CHANNELS; n--)
                past_snap[n] = past_snap[n - CHANNELS];
            for (int n = 0; n < CHANNELS; n++)
                past_snap[n] = {s[2*n], s[2*n+1]};
            for (int i = 0; i < nch; i++) begin
                for (int j = 0; j < nch; j++) begin
                    a = antenna(cut_now, i);
                    b = antenna(cut_now, j);
                    if (a >= nant || b >= nant || !pair_counts(i, j, nch))
                        continue;
                    c = longint'($signed(past_snap[j][31:16]));
                    d = longint'($signed(past_snap[j][15:0]));
                    for (int k = 0; k < nlag; k++) begin
                        addr = k * 256 + a * 16 + b;
                        if (points_in_cut == 0) begin
                            acc_re[addr] = 0;
                            acc_im[addr] = 0;
                            cut_tag[addr] = cut_now + 1;
                        end
                        if (k > points_in_cut)
                            continue;
                        pa = longint'($signed(past_snap[k*CHANNELS+i][31:16]));
                        pb = longint'($signed(past_snap[k*CHANNELS+i][15:0]));
                        acc_re[addr] += pa * c + pb * d;
                        acc_im[addr] += pb * c - pa * d;
                    end
                end
            end
            points_in_cut++;
        end
        if (last) begin
            points_in_cut = 0;
            cut_now++;
            if (cut_now >= clampi(cov_cuts, 1, MAX_CUTS))
                cut_now = 0;
        end
    endfunction

    function automatic t_entry read_entry(logic [10:0] idx);
        t_entry e;
        int lag;
        int row;
        int col;
        int ab;
        int ba;
        longint re;
        longint im;
        lag = idx[10:8];
        row = idx[7:4];
        col = idx[3:0];
        re = 0;
        im = 0;
        e.covered = 1'b0;
        if (lag < clampi(cov_lags, 1, MAX_LAGS) && row < clampi(cov_antennas, 1, MAX_ANTENNAS)
            && col < clampi(cov_antennas, 1, MAX_ANTENNAS)) begin
            ab = lag * 256 + row * 16 + col;
            ba = lag * 256 + col * 16 + row;
            re = acc_re[ab] + acc_re[ba];
            im = acc_im[ab] - acc_im[ba];
            e.covered = cut_tag[ab] != 0 && cut_tag[ba] != 0;
        end
        e.re = re[OUT_W-1:0];
        e.im = im[OUT_W-1:0];
        return e;
    endfunction

    task automatic flag_mismatch(string what, longint got, longint want);
        errors++;
        $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    endtask

    // Output side: random stall bursts until the final stretch.
    int stall_hold = 0;
    always @(posedge i_clk) begin
        if (no_idle) begin
            i_m_tready <= 1'b1;
        end else if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
        end else if (i_m_tready && $urandom_range(0, 5) == 0) begin
            i_m_tready <= 1'b0;
            stall_hold <= $urandom_range(0, 14);
        end else if (!i_m_tready) begin
            i_m_tready <= 1'b1;
            stall_hold <= $urandom_range(0, 20);
        end
    end

    always @(posedge i_clk) begin : check_entries
        t_entry e;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            entries_seen++;
            if (entries_due.size() == 0) begin
                flag_mismatch("unexpected entry", longint'(o_m_tdata[45:0]), 0);
            end else begin
                e = entries_due.pop_front();
                if (o_m_tdata[45:0] !== e.re)
                    flag_mismatch("entry_re", longint'(o_m_tdata[45:0]), longint'(e.re));
                if (o_m_tdata[91:46] !== e.im)
                    flag_mismatch("entry_im", longint'(o_m_tdata[91:46]), longint'(e.im));
                if (o_m_tuser[0] !== e.covered)
                    flag_mismatch("entry_covered", longint'(o_m_tuser[0]), longint'(e.covered));
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [63:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_CHANNELS: cov_channels = value[2:0];
            REG_CUTS:     cov_cuts = value[2:0];
            REG_LAGS:     cov_lags = value[3:0];
            REG_ANTENNAS: cov_antennas = value[4:0];
            REG_CUT_MAP:  cov_map = value;
            default: ;
        endcase
    endtask

    // Sends one item; a typed expectation, when given, replaces the predicted one.
    task automatic send_item(logic [1:0] mode, bit last, logic [10:0] idx,
                             logic [15:0] s [8], bit typed = 1'b0, t_entry want = '{0, 0, 0});
        logic [143:0] data;
        data = '0;
        for (int n = 0; n < 8; n++) data[16*n +: 16] = s[n];
        data[138:128] = idx;
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= data;
        i_s_tuser <= mode;
        i_s_tlast <= last;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        items_sent++;
        case (mode)
            MODE_SNAP:  accumulate_snapshot(s, last);
            MODE_START: clear_stores();
            MODE_READ:  entries_due.push_back(typed ? want : read_entry(idx));
            default: ;
        endcase
    endtask

    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (entries_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_snapshot(bit last);
        logic [15:0] s [8];
        foreach (s[n]) s[n] = rand_sample();
        send_item(MODE_SNAP, last, 11'($urandom), s);
    endtask

    task automatic random_read();
        logic [15:0] s [8];
        logic [10:0] idx;
        int nlag;
        int nant;
        foreach (s[n]) s[n] = 16'($urandom);
        nlag = clampi(cov_lags, 1, MAX_LAGS);
        nant = clampi(cov_antennas, 1, MAX_ANTENNAS);
        if ($urandom_range(0, 6) == 0)
            idx = 11'($urandom);
        else
            idx = {3'($urandom_range(0, nlag - 1)), 4'($urandom_range(0, nant - 1)),
                   4'($urandom_range(0, nant - 1))};
        send_item(MODE_READ, $urandom_range(0, 1), idx, s);
    endtask

    task automatic random_phase(int n_items, logic [2:0] ch, logic [2:0] cuts,
                                logic [3:0] lags, logic [4:0] ants);
        logic [15:0] s [8];
        int stop;
        int run;
        write_reg(REG_CHANNELS, 64'(ch));
        write_reg(REG_CUTS, 64'(cuts));
        write_reg(REG_LAGS, 64'(lags));
        write_reg(REG_ANTENNAS, 64'(ants));
        write_reg(REG_CUT_MAP, {$urandom, $urandom});
        foreach (s[n]) s[n] = 16'($urandom);
        if ($urandom_range(0, 2) != 0) send_item(MODE_START, $urandom_range(0, 1), 11'($urandom), s);
        stop = items_sent + n_items;
        while (items_sent < stop) begin
            case ($urandom_range(0, 19))
                0: send_item($urandom_range(0, 1) ? MODE_NONE : MODE_START,
                             $urandom_range(0, 1), 11'($urandom), s);
                1, 2, 3, 4, 5: repeat ($urandom_range(1, 4)) random_read();
                default: begin
                    run = $urandom_range(1, 12);
                    for (int n = 0; n < run; n++)
                        random_snapshot(n == run - 1 && $urandom_range(0, 4) != 0);
                end
            endcase
        end
        settle();
    endtask

    t_stim_row plan [20];

    initial begin
        logic [15:0] s [8];
        t_entry none;
        none = '{0, 0, 0};
        cov_channels = 3'd4;
        cov_cuts = 3'd1;
        cov_lags = 4'd8;
        cov_antennas = 5'd16;
        cov_map = 64'h3210;
        clear_stores();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Cut 0 puts two channels on antenna 5 and one beyond the antenna count.
        write_reg(REG_CHANNELS, 64'd4);
        write_reg(REG_CUTS, 64'd2);
        write_reg(REG_LAGS, 64'd3);
        write_reg(REG_ANTENNAS, 64'd6);
        write_reg(REG_CUT_MAP, 64'h4132_5950);
        plan = '{
            '{MODE_READ,  0, 11'h000, 16'h0000, 1, none},
            '{MODE_SNAP,  0, 11'h000, 16'h7FFF, 0, none},
            '{MODE_SNAP,  0, 11'h7FF, 16'h8000, 0, none},
            '{MODE_SNAP,  1, 11'h000, 16'h1234, 0, none},
            '{MODE_READ,  0, 11'h000, 16'h0000, 0, none},
            '{MODE_READ,  0, 11'h055, 16'h0000, 0, none},
            '{MODE_READ,  1, 11'h105, 16'hFFFF, 0, none},
            '{MODE_READ,  0, 11'h300, 16'h0000, 1, none},
            '{MODE_READ,  0, 11'h060, 16'h0000, 1, none},
            '{MODE_READ,  0, 11'h099, 16'h0000, 1, none},
            '{MODE_NONE,  1, 11'h7FF, 16'hFFFF, 0, none},
            '{MODE_SNAP,  0, 11'h000, 16'hFFFF, 0, none},
            '{MODE_SNAP,  1, 11'h000, 16'h0001, 0, none},
            '{MODE_SNAP,  0, 11'h000, 16'h5555, 0, none},
            '{MODE_SNAP,  1, 11'h000, 16'hAAAA, 0, none},
            '{MODE_READ,  0, 11'h023, 16'h0000, 0, none},
            '{MODE_READ,  0, 11'h005, 16'h0000, 0, none},
            '{MODE_START, 0, 11'h000, 16'h0000, 0, none},
            '{MODE_READ,  0, 11'h005, 16'h0000, 1, none},
            '{MODE_READ,  0, 11'h7FF, 16'h0000, 1, none}
        };
        foreach (plan[r]) begin
            for (int n = 0; n < 8; n++) s[n] = n[0] ? ~plan[r].fill : plan[r].fill;
            send_item(plan[r].mode, plan[r].last, plan[r].idx, s, plan[r].typed, plan[r].want);
        end
        settle();

        random_phase(170, 3'd4, 3'd4, 4'd8, 5'd16);
        random_phase(170, 3'd1, 3'd1, 4'd1, 5'd1);
        random_phase(170, 3'd0, 3'd7, 4'd15, 5'd31);
        random_phase(170, 3'd2, 3'd3, 4'd4, 5'd8);
        random_phase(170, 3'd7, 3'd0, 4'd0, 5'd0);
        random_phase(170, 3'd3, 3'd2, 4'd8, 5'd4);
        random_phase(110, 3'd2, 3'd1, 4'd2, 5'd16);

        random_phase(170, 3'd4, 3'd4, 4'd3, 5'd12);
        random_phase(170, 3'($urandom_range(1, 4)), 3'($urandom_range(1, 4)),
                     4'($urandom_range(1, 8)), 5'($urandom_range(1, 16)));
        no_idle = 1'b1;
        random_phase(150, 3'd4, 3'd2, 4'd8, 5'd16);

        $display("Sent %0d items across the directed table and random register phases;",
                 items_sent);
        $display("checked %0d matrix entries, %0d mismatches.", entries_seen, errors);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
